FILE: src/aes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, register codes and the s-box for the aes cbc encryptor
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int ROUND_KEY_WORDS = 60;
    localparam int RK_ROWS         = 16;
    localparam int RK_ADDR_W       = $clog2(RK_ROWS);

    localparam logic [2:0] CFG_KEY_BITS_0 = 3'd0;
    localparam logic [2:0] CFG_KEY_BITS_1 = 3'd1;
    localparam logic [2:0] CFG_KEY_BITS_2 = 3'd2;
    localparam logic [2:0] CFG_KEY_BITS_3 = 3'd3;
    localparam logic [2:0] CFG_KEY_LENGTH = 3'd4;
    localparam logic [2:0] CFG_IV_HIGH    = 3'd5;
    localparam logic [2:0] CFG_IV_LOW     = 3'd6;

    localparam logic [1:0] KEY_LEN_128 = 2'd0;
    localparam logic [1:0] KEY_LEN_192 = 2'd1;

    typedef struct packed {
        logic        start_chain;
        logic [31:0] block_word0;
        logic [31:0] block_word1;
        logic [31:0] block_word2;
        logic [31:0] block_word3;
    } t_aes_in;

    typedef struct packed {
        logic [31:0] cipher_word0;
        logic [31:0] cipher_word1;
        logic [31:0] cipher_word2;
        logic [31:0] cipher_word3;
    } t_aes_out;

    typedef struct packed {
        logic init;
        logic last;
    } t_round_ctl;

    localparam logic [2047:0] SBOX_BITS = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_BITS[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage
`default_nettype wire

FILE: src/aes_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: src/aes_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_round (with init set it does the round key add alone)
// one aes round: subbytes, shiftrows, mixcolumns unless last, round key add
// ----------------------------------------------------------------------------
module aes_round
    import aes_pkg::*;
(
    input  wire logic [127:0] i_state,
    input  wire logic [127:0] i_key,
    input  wire t_round_ctl   i_ctl,
    output logic      [127:0] o_state
);

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] t);
        logic [7:0] a0, a1, a2, a3;
        a0 = t[31:24];
        a1 = t[23:16];
        a2 = t[15:8];
        a3 = t[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    logic [31:0] s  [4];
    logic [31:0] sr [4];
    logic [31:0] rd [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            s[c] = sub_word(i_state[127-32*c -: 32]);
        end
        for (int c = 0; c < 4; c++) begin
            sr[c] = {s[c][31:24], s[(c+1)%4][23:16], s[(c+2)%4][15:8], s[(c+3)%4][7:0]};
            rd[c] = i_ctl.last ? sr[c] : mix_col(sr[c]);
        end
        if (i_ctl.init) begin
            o_state = i_state ^ i_key;
        end else begin
            o_state = {rd[0], rd[1], rd[2], rd[3]} ^ i_key;
        end
    end

endmodule
`default_nettype wire

FILE: src/aes_cbc_encrypt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_cbc_encrypt
// aes-128/192/256 cbc encryption, one round per cycle
// ----------------------------------------------------------------------------
// input words carry a 128-bit plaintext block and a start_chain flag;
// output words carry the ciphertext. both use valid/ready.
// the config port writes key, key length and iv registers; the user
// must write them only while idle, the block does not enforce it.
// a word with start_chain set first expands the key schedule of 44, 52
// or 60 words, one key word per cycle, into a 16-row round key ram.
// encryption then reads the first round key row in the load state,
// does the initial key add and then 10, 12 or 14 rounds through the
// shared round unit; the last round writes the result to the output
// register and returns the block to idle to take the next word.
// o_in_ready is high only while idle; a finished result sits in the
// output register, and a new word may be accepted meanwhile. if the
// receiver stalls, the next block waits at its last round.
// reset clears config, chain value and control; the round key ram is
// not cleared and must be filled by a chain start before use.
// ----------------------------------------------------------------------------
module aes_cbc_encrypt
    import aes_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_aes_in     i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_aes_out         o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXPAND,
        S_LOAD,
        S_ROUND
    } t_state;

    t_state        r_state;
    logic [63:0]   r_key [4];
    logic [1:0]    r_key_len;
    logic [127:0]  r_iv;
    logic [127:0]  r_chain;
    logic [127:0]  r_s;
    logic          r_out_valid;
    t_aes_out      r_out;
    logic [5:0]    r_idx;
    logic [2:0]    r_mod;
    logic [7:0]    r_rc;
    logic [31:0]   r_hist [8];
    logic [31:0]   r_row  [3];
    logic [RK_ADDR_W-1:0] r_round;

    logic [3:0]    nk;
    logic [3:0]    nr;
    logic [5:0]    total;
    logic [31:0]   kw_word;
    logic [31:0]   back_word;
    logic [31:0]   t_word;
    logic [31:0]   new_word;
    logic [63:0]   key_reg;
    logic          in_acc;
    logic          final_rnd;
    logic          out_free;
    logic          ram_we;
    logic [RK_ADDR_W-1:0] ram_raddr;
    logic [127:0]  ram_rdata;
    logic [127:0]  rnd_out;
    logic [127:0]  prev;
    t_round_ctl    rnd_ctl;

    always_comb begin
        unique case (r_key_len)
            KEY_LEN_128: begin
                nk        = 4'd4;
                back_word = r_hist[3];
            end
            KEY_LEN_192: begin
                nk        = 4'd6;
                back_word = r_hist[5];
            end
            default: begin
                nk        = 4'd8;
                back_word = r_hist[7];
            end
        endcase
    end

    assign nr       = nk + 4'd6;
    assign total    = {nk + 4'd7, 2'b00};
    assign key_reg  = r_key[r_idx[2:1]];
    assign kw_word  = r_idx[0] ? key_reg[31:0] : key_reg[63:32];

    always_comb begin
        if (r_mod == 3'd0) begin
            t_word = sub_word({r_hist[0][23:0], r_hist[0][31:24]}) ^ {r_rc, 24'h0};
        end else if (nk == 4'd8 && r_mod == 3'd4) begin
            t_word = sub_word(r_hist[0]);
        end else begin
            t_word = r_hist[0];
        end
        new_word = (r_idx < {2'b00, nk}) ? kw_word : (back_word ^ t_word);
    end

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign final_rnd  = (r_state == S_ROUND) && (r_round == nr);
    assign ram_we     = (r_state == S_EXPAND) && (r_idx[1:0] == 2'd3);
    assign prev       = i_in_data.start_chain ? r_iv : r_chain;

    always_comb begin
        if (r_state == S_ROUND) begin
            ram_raddr = (final_rnd && !out_free) ? r_round : r_round + 1'b1;
        end else begin
            ram_raddr = '0;
        end
    end

    assign rnd_ctl.init = (r_round == '0);
    assign rnd_ctl.last = final_rnd;

    aes_ram #(
        .WIDTH(128),
        .DEPTH(RK_ROWS)
    ) u_rk_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_idx[5:2]),
        .i_wdata({r_row[0], r_row[1], r_row[2], new_word}),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    aes_round u_round (
        .i_state(r_s),
        .i_key  (ram_rdata),
        .i_ctl  (rnd_ctl),
        .o_state(rnd_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key[0]    <= '0;
            r_key[1]    <= '0;
            r_key[2]    <= '0;
            r_key[3]    <= '0;
            r_key_len   <= KEY_LEN_128;
            r_iv        <= '0;
            r_chain     <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_mod       <= '0;
            r_rc        <= 8'h01;
            r_round     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KEY_BITS_0: r_key[0]   <= i_cfg_data;
                    CFG_KEY_BITS_1: r_key[1]   <= i_cfg_data;
                    CFG_KEY_BITS_2: r_key[2]   <= i_cfg_data;
                    CFG_KEY_BITS_3: r_key[3]   <= i_cfg_data;
                    CFG_KEY_LENGTH: r_key_len  <= i_cfg_data[1:0];
                    CFG_IV_HIGH:    r_iv[127:64] <= i_cfg_data;
                    CFG_IV_LOW:     r_iv[63:0]   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (final_rnd && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_s <= {i_in_data.block_word0, i_in_data.block_word1,
                                i_in_data.block_word2, i_in_data.block_word3} ^ prev;
                        r_idx <= '0;
                        r_mod <= '0;
                        r_rc  <= 8'h01;
                        r_state <= i_in_data.start_chain ? S_EXPAND : S_LOAD;
                    end
                end
                S_EXPAND: begin
                    for (int k = 7; k > 0; k--) begin
                        r_hist[k] <= r_hist[k-1];
                    end
                    r_hist[0] <= new_word;
                    if (r_idx[1:0] != 2'd3) begin
                        r_row[r_idx[1:0]] <= new_word;
                    end
                    if ({1'b0, r_mod} == nk - 4'd1) begin
                        r_mod <= '0;
                    end else begin
                        r_mod <= r_mod + 3'd1;
                    end
                    if (r_idx >= {2'b00, nk} && r_mod == 3'd0) begin
                        r_rc <= {r_rc[6:0], 1'b0} ^ (r_rc[7] ? 8'h1b : 8'h00);
                    end
                    r_idx <= r_idx + 6'd1;
                    if (r_idx == total - 6'd1) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (!final_rnd) begin
                        r_s     <= rnd_out;
                        r_round <= r_round + 1'b1;
                    end else if (out_free) begin
                        r_out       <= rnd_out;
                        r_chain     <= rnd_out;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
